/* hw/rtl/sfd_pkg.sv */
// Shared types and constants for the stuffed frame deframer.
package sfd_pkg;

  localparam int unsigned ByteW = 8;
  localparam int unsigned CfgIdxW = 2;

  // Configuration register indexes.
  localparam logic [CfgIdxW-1:0] CfgStartCode = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgEndCode = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgEscapeCode = 2'd2;
  localparam logic [CfgIdxW-1:0] CfgEscapeMask = 2'd3;

  // Reset values of the configuration registers.
  localparam logic [ByteW-1:0] RstStartCode = 8'd2;
  localparam logic [ByteW-1:0] RstEndCode = 8'd3;
  localparam logic [ByteW-1:0] RstEscapeCode = 8'd16;
  localparam logic [ByteW-1:0] RstEscapeMask = 8'd32;

  typedef enum logic [1:0] {
    KIND_DATA  = 2'd0,
    KIND_GOOD  = 2'd1,
    KIND_BAD   = 2'd2,
    KIND_STRAY = 2'd3
  } kind_e;

  typedef struct packed {
    logic [ByteW-1:0] start_code;
    logic [ByteW-1:0] end_code;
    logic [ByteW-1:0] escape_code;
    logic [ByteW-1:0] escape_mask;
  } cfg_t;

  typedef struct packed {
    kind_e            kind;
    logic [ByteW-1:0] data;
  } res_t;

endpackage

/* hw/rtl/sfd_cfg.sv */
// Configuration register file of the deframer.
module sfd_cfg (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [sfd_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  logic [sfd_pkg::ByteW-1:0]   cfg_wdata_i,
  output sfd_pkg::cfg_t               cfg_o
);

  sfd_pkg::cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        sfd_pkg::CfgStartCode:  cfg_d.start_code = cfg_wdata_i;
        sfd_pkg::CfgEndCode:    cfg_d.end_code = cfg_wdata_i;
        sfd_pkg::CfgEscapeCode: cfg_d.escape_code = cfg_wdata_i;
        sfd_pkg::CfgEscapeMask: cfg_d.escape_mask = cfg_wdata_i;
        default:                cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.start_code <= sfd_pkg::RstStartCode;
      cfg_q.end_code <= sfd_pkg::RstEndCode;
      cfg_q.escape_code <= sfd_pkg::RstEscapeCode;
      cfg_q.escape_mask <= sfd_pkg::RstEscapeMask;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

/* hw/rtl/sfd_fsm.sv */
// Frame state machine: tracks phase, length, escape; at most one result per byte.
module sfd_fsm (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  sfd_pkg::cfg_t             cfg_i,
  input  logic                      beat_i,
  input  logic [sfd_pkg::ByteW-1:0] byte_i,
  output logic                      res_valid_o,
  output sfd_pkg::res_t             res_o
);

  typedef enum logic [3:0] {
    PH_IDLE = 4'b0001,
    PH_LEN  = 4'b0010,
    PH_DATA = 4'b0100,
    PH_END  = 4'b1000
  } phase_e;

  phase_e                    phase_q, phase_d;
  logic [sfd_pkg::ByteW-1:0] bytes_left_q, bytes_left_d;
  logic                      esc_q, esc_d;

  always_comb begin
    phase_d = phase_q;
    bytes_left_d = bytes_left_q;
    esc_d = esc_q;
    res_valid_o = 1'b0;
    res_o.kind = sfd_pkg::KIND_DATA;
    res_o.data = '0;
    if (beat_i) begin
      unique case (phase_q)
        PH_IDLE: begin
          if (byte_i == cfg_i.start_code) begin
            phase_d = PH_LEN;
          end else begin
            res_valid_o = 1'b1;
            res_o.kind = sfd_pkg::KIND_STRAY;
          end
        end
        PH_LEN: begin
          bytes_left_d = byte_i;
          esc_d = 1'b0;
          phase_d = (byte_i == '0) ? PH_END : PH_DATA;
        end
        PH_DATA: begin
          if (esc_q) begin
            res_valid_o = 1'b1;
            res_o.data = byte_i ^ cfg_i.escape_mask;
            esc_d = 1'b0;
          end else if (byte_i == cfg_i.escape_code) begin
            esc_d = 1'b1;
          end else begin
            res_valid_o = 1'b1;
            res_o.data = byte_i;
          end
          bytes_left_d = bytes_left_q - 1'b1;
          // Last stuffed byte: a dangling escape is forgotten here.
          if (bytes_left_q == sfd_pkg::ByteW'(1)) begin
            esc_d = 1'b0;
            phase_d = PH_END;
          end
        end
        PH_END: begin
          res_valid_o = 1'b1;
          res_o.kind = (byte_i == cfg_i.end_code) ? sfd_pkg::KIND_GOOD : sfd_pkg::KIND_BAD;
          esc_d = 1'b0;
          bytes_left_d = '0;
          phase_d = PH_IDLE;
        end
        default: begin
          phase_d = PH_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      bytes_left_q <= '0;
      esc_q <= 1'b0;
    end else begin
      phase_q <= phase_d;
      bytes_left_q <= bytes_left_d;
      esc_q <= esc_d;
    end
  end

  // While in payload at least one stuffed byte is still owed.
  a_data_has_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PH_DATA |-> bytes_left_q != '0)
    else $error("payload phase with zero bytes left");

  // An escape can only be pending inside the payload.
  a_esc_in_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    esc_q |-> phase_q == PH_DATA)
    else $error("escape pending outside payload");

  // The byte after a pending escape always yields a payload byte.
  a_esc_emits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (beat_i && esc_q) |-> (res_valid_o && res_o.kind == sfd_pkg::KIND_DATA))
    else $error("escaped byte produced no payload result");

endmodule

/* hw/rtl/sfd_obuf.sv */
// Two-entry output buffer that decouples the result stream from the input.
module sfd_obuf (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  sfd_pkg::res_t push_data_i,
  output logic          ready_o,
  output logic          valid_o,
  input  logic          pop_ready_i,
  output sfd_pkg::res_t data_o
);

  logic [1:0]    count_q, count_d;
  sfd_pkg::res_t slot0_q, slot0_d;
  sfd_pkg::res_t slot1_q, slot1_d;
  logic          pop;

  assign valid_o = (count_q != 2'd0);
  assign ready_o = (count_q != 2'd2);
  assign data_o = slot0_q;
  assign pop = valid_o && pop_ready_i;

  always_comb begin
    count_d = count_q;
    slot0_d = slot0_q;
    slot1_d = slot1_q;
    if (pop && push_i) begin
      if (count_q == 2'd1) begin
        slot0_d = push_data_i;
      end else begin
        slot0_d = slot1_q;
        slot1_d = push_data_i;
      end
    end else if (pop) begin
      slot0_d = slot1_q;
      count_d = count_q - 2'd1;
    end else if (push_i) begin
      if (count_q == 2'd0) begin
        slot0_d = push_data_i;
      end else begin
        slot1_d = push_data_i;
      end
      count_d = count_q + 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else begin
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    slot0_q <= slot0_d;
    slot1_q <= slot1_d;
  end

  // A push is only ever offered while there is room for it.
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> count_q != 2'd2)
    else $error("result pushed into a full buffer");

endmodule

/* hw/rtl/stuffed_frame_deframer_core.sv */
// Top level of the length-prefixed, byte-stuffed frame deframer.
//
//   Channel   Direction  Beat content
//   s_axis    in         tdata[7:0] = rx_byte
//   m_axis    out        tdata[7:0] = out_byte, tuser[1:0] = out_kind
//   cfg       in         write of start_code, end_code, escape_code, escape_mask
//
// Unless stalled, one received byte is taken per cycle. Each byte runs through
// the frame state machine in the cycle it is accepted, and its result, if
// any, lands in a two-entry output buffer in the next cycle. Input stalls
// only when that buffer is full, so the sustained rate is one byte per cycle
// while the sink keeps up. Reset returns the state machine to idle and the
// configuration registers to their default codes; no clearing pass is needed.
module stuffed_frame_deframer_core (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // Received link bytes.
  input  logic                        s_axis_tvalid,
  output logic                        s_axis_tready,
  input  logic [sfd_pkg::ByteW-1:0]   s_axis_tdata,   // [7:0] rx_byte
  // Unescaped payload bytes and frame status.
  output logic                        m_axis_tvalid,
  input  logic                        m_axis_tready,
  output logic [sfd_pkg::ByteW-1:0]   m_axis_tdata,   // [7:0] out_byte
  output logic [1:0]                  m_axis_tuser,   // [1:0] out_kind
  // Configuration writes.
  input  logic                        cfg_we_i,
  input  logic [sfd_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  logic [sfd_pkg::ByteW-1:0]   cfg_wdata_i
);

  sfd_pkg::cfg_t cfg;
  sfd_pkg::res_t res;
  sfd_pkg::res_t out_res;
  logic          res_valid;
  logic          in_beat;

  // A byte is consumed exactly when the handshake completes.
  assign in_beat = s_axis_tvalid && s_axis_tready;

  sfd_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  // The state machine decodes the byte against the current codes.
  sfd_fsm u_fsm (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .beat_i      (in_beat),
    .byte_i      (s_axis_tdata),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  // The buffer holds up to two results so the input keeps flowing while
  // a finished result waits for the sink.
  sfd_obuf u_obuf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (res_valid),
    .push_data_i (res),
    .ready_o     (s_axis_tready),
    .valid_o     (m_axis_tvalid),
    .pop_ready_i (m_axis_tready),
    .data_o      (out_res)
  );

  assign m_axis_tdata = out_res.data;
  assign m_axis_tuser = out_res.kind;

endmodule
